@@ rtl/mlpt_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the page table walker.
package mlpt_pkg;

  localparam int unsigned MAX_PAGE_BITS = 20;
  localparam int unsigned TABLE_SLOTS   = 64;
  localparam int unsigned FRAME_BITS    = 20;

  localparam int unsigned PAGE_W    = 20;
  localparam int unsigned FRAME_W   = 20;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned OFF_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned SLOT_W    = (MAX_PAGE_BITS + 1) / 2;
  localparam int unsigned TBL_W     = $clog2(TABLE_SLOTS);
  localparam int unsigned ADDR_W    = TBL_W + SLOT_W;
  localparam int unsigned DEPTH     = TABLE_SLOTS * (2 ** SLOT_W);
  localparam int unsigned ENTRY_W   = FRAME_W + 1;
  localparam int unsigned CNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned BITS_W    = 5;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [OFF_W-1:0] MIN_OFFSET = OFF_W'(32 - MAX_PAGE_BITS);
  localparam logic [OFF_W-1:0] MAX_OFFSET = OFF_W'(29);

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MAP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNMAP  = 2'd2;

  localparam logic [LVL_W-1:0] LEVELS_TWO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_OFFSET = 1'b1;

  localparam logic [TBL_W-1:0] ROOT_TABLE = '0;

  typedef enum logic [1:0] {
    SRC_ROOT,
    SRC_MID,
    SRC_LEAF
  } rd_src_e;

  typedef enum logic [1:0] {
    WR_SWEEP,
    WR_LINK,
    WR_LEAF
  } wr_kind_e;

  typedef struct packed {
    logic     cap_item;
    logic     rd_en;
    rd_src_e  rd_src;
    logic     lat_e0;
    logic     lat_e1;
    logic     lat_e2;
    logic     lat_exh;
    logic     wr_en;
    wr_kind_e wr_kind;
    logic     sweep_root;
    logic     cnt_inc;
    logic     link_lvl;
    logic     load_out;
  } mlpt_cmd_t;

  typedef struct packed {
    logic             three;
    logic [REQ_W-1:0] req;
    logic             p1_now;
    logic             p2_now;
    logic             p1;
    logic             p2;
    logic             exh_now;
    logic             sweep_last;
    logic             out_free;
  } mlpt_sts_t;

endpackage

@@ rtl/mlpt_ram.sv @@
// Generic simple dual-port RAM with registered read.
module mlpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mlpt_ctrl.sv @@
// Walk controller: sequences table reads, subtable clears, links, leaf writes and result hand-off.
module mlpt_ctrl import mlpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mlpt_sts_t sts_i,
  output mlpt_cmd_t cmd_o
);

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_E0   = 4'd2;
  localparam logic [3:0] ST_E1   = 4'd3;
  localparam logic [3:0] ST_E2   = 4'd4;
  localparam logic [3:0] ST_ACT  = 4'd5;
  localparam logic [3:0] ST_CLR0 = 4'd6;
  localparam logic [3:0] ST_LNK0 = 4'd7;
  localparam logic [3:0] ST_CLR1 = 4'd8;
  localparam logic [3:0] ST_LNK1 = 4'd9;
  localparam logic [3:0] ST_LEAF = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_src  = SRC_ROOT;
    cmd_o.wr_kind = WR_SWEEP;
    case (state_q)
      ST_INIT: begin
        // root table starts cleared
        cmd_o.wr_en      = 1'b1;
        cmd_o.sweep_root = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = SRC_ROOT;
          state_d        = ST_E0;
        end
      end
      ST_E0: begin
        cmd_o.lat_e0 = 1'b1;
        if (sts_i.p1_now) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = SRC_MID;
          state_d      = ST_E1;
        end else if (sts_i.req == REQ_LOOKUP) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_ACT;
        end
      end
      ST_E1: begin
        cmd_o.lat_e1 = 1'b1;
        if (sts_i.req == REQ_LOOKUP) begin
          if (sts_i.p2_now) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_src = SRC_LEAF;
            state_d      = ST_E2;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_ACT;
        end
      end
      ST_E2: begin
        cmd_o.lat_e2 = 1'b1;
        state_d      = ST_DONE;
      end
      ST_ACT: begin
        case (sts_i.req)
          REQ_MAP: begin
            cmd_o.lat_exh = 1'b1;
            if (sts_i.exh_now) begin
              state_d = ST_DONE;
            end else if (!sts_i.p1) begin
              state_d = ST_CLR0;
            end else if (sts_i.three && !sts_i.p2) begin
              state_d = ST_CLR1;
            end else begin
              state_d = ST_LEAF;
            end
          end
          REQ_UNMAP: begin
            if (sts_i.p1 && (!sts_i.three || sts_i.p2)) state_d = ST_LEAF;
            else state_d = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_CLR0, ST_CLR1: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_kind = WR_SWEEP;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.sweep_last) state_d = (state_q == ST_CLR0) ? ST_LNK0 : ST_LNK1;
      end
      ST_LNK0: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_kind  = WR_LINK;
        cmd_o.link_lvl = 1'b0;
        state_d        = sts_i.three ? ST_CLR1 : ST_LEAF;
      end
      ST_LNK1: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_kind  = WR_LINK;
        cmd_o.link_lvl = 1'b1;
        state_d        = ST_LEAF;
      end
      ST_LEAF: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_kind = WR_LEAF;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/mlpt_dp.sv @@
// Walk datapath: configuration, index split, entry checks, allocation count and result register.
module mlpt_dp import mlpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [PAGE_W-1:0]    page_number_i,
  input  logic [FRAME_W-1:0]   frame_number_i,
  input  mlpt_cmd_t            cmd_i,
  output mlpt_sts_t            sts_o,
  output logic                 ram_we_o,
  output logic [ADDR_W-1:0]    ram_waddr_o,
  output logic [ENTRY_W-1:0]   ram_wdata_o,
  output logic                 ram_re_o,
  output logic [ADDR_W-1:0]    ram_raddr_o,
  input  logic [ENTRY_W-1:0]   ram_rdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic [FRAME_W-1:0]   frame_out_o,
  output logic [LVL_W-1:0]     levels_read_o,
  output logic                 pool_exhausted_o,
  output logic [CNT_W-1:0]     tables_in_use_o
);

  function automatic logic [BITS_W-1:0] div3(input logic [BITS_W-1:0] v);
    logic [BITS_W-1:0] r;
    case (v)
      5'd3, 5'd4, 5'd5:    r = 5'd1;
      5'd6, 5'd7, 5'd8:    r = 5'd2;
      5'd9, 5'd10, 5'd11:  r = 5'd3;
      5'd12, 5'd13, 5'd14: r = 5'd4;
      5'd15, 5'd16, 5'd17: r = 5'd5;
      5'd18, 5'd19, 5'd20: r = 5'd6;
      5'd21, 5'd22, 5'd23: r = 5'd7;
      5'd24, 5'd25, 5'd26: r = 5'd8;
      5'd27, 5'd28, 5'd29: r = 5'd9;
      5'd30, 5'd31:        r = 5'd10;
      default:             r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] field(input logic [PAGE_W-1:0] page,
                                               input logic [BITS_W-1:0] shift,
                                               input logic [BITS_W-1:0] bits);
    logic [PAGE_W-1:0] sh;
    logic [PAGE_W-1:0] mask;
    sh   = page >> shift;
    mask = ~({PAGE_W{1'b1}} << bits);
    return SLOT_W'(sh & mask);
  endfunction

  logic [LVL_W-1:0]   level_count_q;
  logic [OFF_W-1:0]   page_off_q;
  logic [REQ_W-1:0]   req_q;
  logic [FRAME_W-1:0] frame_q;
  logic [SLOT_W-1:0]  idx0_q, idx1_q, idx2_q;
  logic               p1_q, p2_q, exh_q;
  logic [TBL_W-1:0]   t1_q, t2_q;
  logic [ENTRY_W-1:0] e1_q, e2_q;
  logic [CNT_W-1:0]   alloc_q;
  logic [SLOT_W-1:0]  cnt_q;
  logic               out_valid_q;
  logic               hit_q, exh_out_q;
  logic [FRAME_W-1:0] fout_q;
  logic [LVL_W-1:0]   lv_q;
  logic [CNT_W-1:0]   tiu_q;

  logic               three;
  logic [OFF_W-1:0]   off_c;
  logic [BITS_W-1:0]  pb, d3, b0, b1, b2, s0;
  logic [SLOT_W-1:0]  idx0_c, idx1_c, idx2_c;
  logic               ptr_ok;
  logic [1:0]         need;
  logic               exh_now;
  logic [TBL_W-1:0]   sweep_tbl;
  logic               is_lookup, hit_c;
  logic [LVL_W-1:0]   lv_c;
  logic [FRAME_W-1:0] fout_c;
  logic               do_link;

  assign three = (level_count_q != LEVELS_TWO);

  // index split under the current layout
  always_comb begin
    if (page_off_q < MIN_OFFSET) off_c = MIN_OFFSET;
    else if (page_off_q > MAX_OFFSET) off_c = MAX_OFFSET;
    else off_c = page_off_q;
    pb = BITS_W'(6'd32 - {1'b0, off_c});
    d3 = div3(pb);
    if (three) begin
      b0 = d3;
      b1 = d3;
      b2 = pb - (d3 << 1);
    end else begin
      b0 = pb >> 1;
      b1 = pb - (pb >> 1);
      b2 = '0;
    end
    s0     = b1 + b2;
    idx0_c = field(page_number_i, s0, b0);
    idx1_c = field(page_number_i, b2, b1);
    idx2_c = field(page_number_i, '0, b2);
  end

  // upper-level entry points at an allocated table
  assign ptr_ok = ram_rdata_i[ENTRY_W-1] && (ram_rdata_i[FRAME_W-1:CNT_W] == '0) &&
                  (ram_rdata_i[CNT_W-1:0] < alloc_q);

  always_comb begin
    if (!p1_q) need = three ? 2'd2 : 2'd1;
    else if (three && !p2_q) need = 2'd1;
    else need = 2'd0;
  end
  assign exh_now = ({1'b0, alloc_q} + {{(CNT_W-1){1'b0}}, need}) > (CNT_W+1)'(TABLE_SLOTS);

  assign sweep_tbl = cmd_i.sweep_root ? ROOT_TABLE : alloc_q[TBL_W-1:0];
  assign do_link   = cmd_i.wr_en && (cmd_i.wr_kind == WR_LINK);

  always_comb begin
    ram_we_o    = cmd_i.wr_en;
    ram_waddr_o = {sweep_tbl, cnt_q};
    ram_wdata_o = '0;
    case (cmd_i.wr_kind)
      WR_SWEEP: begin
        ram_waddr_o = {sweep_tbl, cnt_q};
        ram_wdata_o = '0;
      end
      WR_LINK: begin
        ram_waddr_o = cmd_i.link_lvl ? {t1_q, idx1_q} : {ROOT_TABLE, idx0_q};
        ram_wdata_o = {1'b1, FRAME_W'(alloc_q[TBL_W-1:0])};
      end
      WR_LEAF: begin
        ram_waddr_o = three ? {t2_q, idx2_q} : {t1_q, idx1_q};
        ram_wdata_o = (req_q == REQ_MAP) ? {1'b1, frame_q} : '0;
      end
      default: begin
        ram_waddr_o = {sweep_tbl, cnt_q};
        ram_wdata_o = '0;
      end
    endcase
  end

  always_comb begin
    ram_re_o = cmd_i.rd_en;
    case (cmd_i.rd_src)
      SRC_ROOT: ram_raddr_o = {ROOT_TABLE, idx0_c};
      SRC_MID:  ram_raddr_o = {ram_rdata_i[TBL_W-1:0], idx1_q};
      SRC_LEAF: ram_raddr_o = {ram_rdata_i[TBL_W-1:0], idx2_q};
      default:  ram_raddr_o = {ROOT_TABLE, idx0_c};
    endcase
  end

  always_comb begin
    is_lookup = (req_q == REQ_LOOKUP);
    hit_c     = is_lookup && p1_q && (three ? (p2_q && e2_q[ENTRY_W-1]) : e1_q[ENTRY_W-1]);
    if (!is_lookup) lv_c = 2'd0;
    else if (!p1_q) lv_c = 2'd1;
    else if (three && p2_q) lv_c = 2'd3;
    else lv_c = 2'd2;
    if (hit_c) fout_c = three ? e2_q[FRAME_W-1:0] : e1_q[FRAME_W-1:0];
    else fout_c = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= 2'd3;
      page_off_q    <= 5'd12;
      alloc_q       <= CNT_W'(1);
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      p1_q          <= 1'b0;
      p2_q          <= 1'b0;
      exh_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEVEL_COUNT: level_count_q <= cfg_data_i[LVL_W-1:0];
          CFG_PAGE_OFFSET: page_off_q    <= cfg_data_i[OFF_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.cap_item) begin
        p1_q  <= 1'b0;
        p2_q  <= 1'b0;
        exh_q <= 1'b0;
      end
      if (cmd_i.lat_e0) p1_q <= ptr_ok;
      if (cmd_i.lat_e1) p2_q <= three && ptr_ok;
      if (cmd_i.lat_exh) exh_q <= exh_now;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + SLOT_W'(1);
      if (do_link) alloc_q <= alloc_q + CNT_W'(1);
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      req_q   <= req_type_i;
      frame_q <= frame_number_i;
      idx0_q  <= idx0_c;
      idx1_q  <= idx1_c;
      idx2_q  <= idx2_c;
    end
    if (cmd_i.lat_e0) t1_q <= ram_rdata_i[TBL_W-1:0];
    if (cmd_i.lat_e1) begin
      e1_q <= ram_rdata_i;
      t2_q <= ram_rdata_i[TBL_W-1:0];
    end
    if (cmd_i.lat_e2) e2_q <= ram_rdata_i;
    if (do_link) begin
      if (cmd_i.link_lvl) t2_q <= alloc_q[TBL_W-1:0];
      else t1_q <= alloc_q[TBL_W-1:0];
    end
    if (cmd_i.load_out) begin
      hit_q     <= hit_c;
      fout_q    <= fout_c;
      lv_q      <= lv_c;
      exh_out_q <= (req_q == REQ_MAP) && exh_q;
      tiu_q     <= alloc_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.three      = three;
    sts_o.req        = req_q;
    sts_o.p1_now     = ptr_ok;
    sts_o.p2_now     = three && ptr_ok;
    sts_o.p1         = p1_q;
    sts_o.p2         = p2_q;
    sts_o.exh_now    = exh_now;
    sts_o.sweep_last = &cnt_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign frame_out_o      = fout_q;
  assign levels_read_o    = lv_q;
  assign pool_exhausted_o = exh_out_q;
  assign tables_in_use_o  = tiu_q;

endmodule

@@ rtl/multi_level_page_table_walk_unit.sv @@
// Two- or three-level page table walker with on-demand subtable allocation. After reset the
// root table is cleared, during which no item is taken (configuration writes
// still are). Each item is walked one at a time through an entry memory with a registered read
// and at most one access per cycle. A lookup steps through accept, one state per table level
// read and hand-off, with its result registered at hand-off; any other item passes an action
// step after the reads, and every subtable a map allocates has its 1024 entries cleared and
// is linked before the leaf write. Results wait in an output register, so the next item can
// be taken before the previous result has been consumed; hand-off stalls only while that
// register still holds a result that is not being taken.
module multi_level_page_table_walk_unit import mlpt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // page_number, frame_number
  input  logic [REQ_W-1:0]      s_axis_tuser,   // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // hit, frame_out, levels_read,
                                                // pool_exhausted, tables_in_use, pad
);

  mlpt_cmd_t          cmd;
  mlpt_sts_t          sts;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic               hit, exh;
  logic [FRAME_W-1:0] frame_out;
  logic [LVL_W-1:0]   levels_read;
  logic [CNT_W-1:0]   tables_in_use;

  mlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlpt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (s_axis_tuser),
    .page_number_i    (s_axis_tdata[PAGE_W-1:0]),
    .frame_number_i   (s_axis_tdata[PAGE_W+FRAME_W-1:PAGE_W]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .hit_o            (hit),
    .frame_out_o      (frame_out),
    .levels_read_o    (levels_read),
    .pool_exhausted_o (exh),
    .tables_in_use_o  (tables_in_use)
  );

  mlpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = {1'b0, tables_in_use, exh, levels_read, frame_out, hit};

endmodule

@@ rtl/mlpt_chk.sv @@
// Port-level checker for the page table walker, bound to the top level.
module mlpt_chk import mlpt_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in flight: no back-to-back acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while walking");

  // a hit reports a walk of at least two levels and a miss has no frame
  a_hit_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] ? (m_axis_tdata[22:21] == 2'd2 ||
                                          m_axis_tdata[22:21] == 2'd3)
                                       : (m_axis_tdata[20:1] == '0)))
    else $error("hit and walk depth disagree");

  // exhausted map reports no lookup fields
  a_exh_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23] |-> !m_axis_tdata[0] && (m_axis_tdata[22:21] == 2'd0))
    else $error("exhausted result carries lookup data");

  // allocated table count stays within the pool
  a_pool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[30:24] != '0) &&
                      (m_axis_tdata[30:24] <= CNT_W'(TABLE_SLOTS)))
    else $error("table count out of range");

endmodule

bind multi_level_page_table_walk_unit mlpt_chk u_mlpt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
